FILE: sv/tfn_pkg.sv
// Shared widths, pipeline state types and per-stage step functions for the
// triangle face normal unit. No dependencies.
package tfn_pkg;

   // Field widths
   localparam int COORD_WIDTH      = 16;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int OUT_WIDTH        = 16;
   localparam int NUM_COORDS       = 9;
   localparam int NUM_AXES         = 3;

   // Beat widths
   localparam int REQ_DATA_W = NUM_COORDS * COORD_WIDTH;
   localparam int RSP_DATA_W = NUM_AXES * OUT_WIDTH;

   // Internal widths
   localparam int DIFF_W  = COORD_WIDTH + 1;        // edge vector component
   localparam int PROD_W  = 2 * DIFF_W;             // one cross product term
   localparam int CROSS_W = PROD_W + 1;             // signed cross component
   localparam int MAG_W   = PROD_W;                 // its magnitude
   localparam int HALF_W  = MAG_W / 2;              // split for squaring
   localparam int PART_W  = 2 * HALF_W;             // one partial product
   localparam int SUM_W   = 2 * MAG_W;              // sum of squares
   localparam int QUO_W   = 2 * NORMAL_FRAC_BITS + 1;
   localparam int ROOT_W  = NORMAL_FRAC_BITS + 1;
   localparam int TRIAL_W = QUO_W + 2;

   // State of one restoring division lane
   typedef struct packed {
      logic [SUM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_state_type;

   // State of one square root lane
   typedef struct packed {
      logic [QUO_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_state_type;

   // One quotient bit: shift the remainder (except on the first step),
   // then compare against the divisor and subtract when it fits.
   function automatic div_state_type div_step(div_state_type cur,
                                              logic [SUM_W-1:0] divisor,
                                              logic first);
      logic [SUM_W:0] shifted;
      logic [SUM_W:0] diff;
      logic           fits;
      div_state_type  nxt;
      shifted = first ? {1'b0, cur.rem} : {cur.rem, 1'b0};
      diff    = shifted - {1'b0, divisor};
      fits    = (shifted >= {1'b0, divisor});
      nxt.rem = fits ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
      nxt.quo = {cur.quo[QUO_W-2:0], fits};
      return nxt;
   endfunction

   // One root bit: the remainder holds radicand minus root squared.
   function automatic sqrt_state_type sqrt_step(sqrt_state_type cur, int bit_pos);
      logic [TRIAL_W-1:0] trial;
      logic               fits;
      sqrt_state_type     nxt;
      trial = (TRIAL_W'(cur.root) << (bit_pos + 1)) | (TRIAL_W'(1) << (2 * bit_pos));
      fits  = (TRIAL_W'(cur.rem) >= trial);
      nxt.rem  = fits ? (cur.rem - trial[QUO_W-1:0]) : cur.rem;
      nxt.root = cur.root | (ROOT_W'(fits) << bit_pos);
      return nxt;
   endfunction

endpackage

FILE: sv/triangle_face_normal_unit.sv
// Triangle face normal unit: edge vectors, cross product, unit scaling.
// Depends on tfn_pkg for widths, lane state types and step functions.
//
// Takes one triangle per beat and returns its unit face normal in Q1.14,
// truncated toward zero, with a degenerate flag for zero-area triangles.
// The unit is a 51-stage pipeline: six stages form the edge vectors, the
// cross product and the exact sum of squares, 29 stages run a restoring
// division (one quotient bit per stage) of each squared component by that
// sum, 15 stages take the square root one bit per stage, and one output
// register holds the result. A new triangle is accepted every cycle unless
// the result side stalls; then the whole pipeline holds and nothing is
// dropped or repeated.
module triangle_face_normal_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each, lowest first)
   input  logic [tfn_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // normal_x, normal_y, normal_z (16 bits each, lowest first)
   output logic [tfn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // degenerate
   output logic                           rsp_tuser
);
   import tfn_pkg::*;

   // Global advance: the pipeline moves when the output slot is free or taken.
   logic rsp_tvalid_ff;
   logic adv;
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // Unpack the vertex coordinates.
   logic [COORD_WIDTH-1:0] crd [NUM_COORDS];
   always_comb begin
      for (int c = 0; c < NUM_COORDS; c++) begin
         crd[c] = req_tdata[c*COORD_WIDTH +: COORD_WIDTH];
      end
   end

   // Stage 1: edge vectors U = B - A (0..2) and V = C - A (3..5).
   logic signed [DIFF_W-1:0] edge_in [6];
   logic signed [DIFF_W-1:0] edge_ff [6];
   logic                     v1_ff;
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         edge_in[a]   = $signed({crd[3+a][COORD_WIDTH-1], crd[3+a]})
                      - $signed({crd[a][COORD_WIDTH-1], crd[a]});
         edge_in[3+a] = $signed({crd[6+a][COORD_WIDTH-1], crd[6+a]})
                      - $signed({crd[a][COORD_WIDTH-1], crd[a]});
      end
   end

   // Stage 2: the six cross product terms, paired per component.
   logic signed [PROD_W-1:0] prod_in [6];
   logic signed [PROD_W-1:0] prod_ff [6];
   logic                     v2_ff;
   always_comb begin
      prod_in[0] = edge_ff[1] * edge_ff[5];   // uy * vz
      prod_in[1] = edge_ff[2] * edge_ff[4];   // uz * vy
      prod_in[2] = edge_ff[2] * edge_ff[3];   // uz * vx
      prod_in[3] = edge_ff[0] * edge_ff[5];   // ux * vz
      prod_in[4] = edge_ff[0] * edge_ff[4];   // ux * vy
      prod_in[5] = edge_ff[1] * edge_ff[3];   // uy * vx
   end

   // Stage 3: cross components as sign and magnitude.
   logic signed [CROSS_W-1:0] cross_c [NUM_AXES];
   logic [MAG_W-1:0]          mag_in  [NUM_AXES];
   logic [MAG_W-1:0]          mag_ff  [NUM_AXES];
   logic [NUM_AXES-1:0]       neg3_in;
   logic [NUM_AXES-1:0]       neg3_ff;
   logic                      v3_ff;
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         cross_c[a] = CROSS_W'(prod_ff[2*a]) - CROSS_W'(prod_ff[2*a+1]);
         neg3_in[a] = cross_c[a][CROSS_W-1];
         mag_in[a]  = neg3_in[a] ? MAG_W'(-cross_c[a]) : MAG_W'(cross_c[a]);
      end
   end

   // Stage 4: partial products of each square from the half words.
   logic [PART_W-1:0]   hh_in [NUM_AXES];
   logic [PART_W-1:0]   hl_in [NUM_AXES];
   logic [PART_W-1:0]   ll_in [NUM_AXES];
   logic [PART_W-1:0]   hh_ff [NUM_AXES];
   logic [PART_W-1:0]   hl_ff [NUM_AXES];
   logic [PART_W-1:0]   ll_ff [NUM_AXES];
   logic [NUM_AXES-1:0] neg4_ff;
   logic                v4_ff;
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         hh_in[a] = mag_ff[a][MAG_W-1:HALF_W] * mag_ff[a][MAG_W-1:HALF_W];
         hl_in[a] = mag_ff[a][MAG_W-1:HALF_W] * mag_ff[a][HALF_W-1:0];
         ll_in[a] = mag_ff[a][HALF_W-1:0] * mag_ff[a][HALF_W-1:0];
      end
   end

   // Stage 5: assemble the exact squares.
   logic [SUM_W-1:0]    sq_in [NUM_AXES];
   logic [SUM_W-1:0]    sq_ff [NUM_AXES];
   logic [NUM_AXES-1:0] neg5_ff;
   logic                v5_ff;
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         sq_in[a] = (SUM_W'(hh_ff[a]) << (2 * HALF_W))
                  + (SUM_W'(hl_ff[a]) << (HALF_W + 1))
                  + SUM_W'(ll_ff[a]);
      end
   end

   // Stage 6 loads the division lanes with the squares and their sum.
   logic [SUM_W-1:0] sum_in;
   assign sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];

   // Division lanes: quotient = square * 2^(2F) / sum, one bit per stage.
   div_state_type       d_ff   [0:QUO_W][NUM_AXES];
   div_state_type       d_in   [1:QUO_W][NUM_AXES];
   logic [SUM_W-1:0]    dsum_ff [0:QUO_W-1];
   logic [NUM_AXES-1:0] dneg_ff [0:QUO_W];
   logic                ddeg_ff [0:QUO_W];
   logic                dv_ff   [0:QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
         assign d_in[k+1][a] = div_step(d_ff[k][a], dsum_ff[k], k == 0);
      end
   end

   // Square root lanes: root of the quotient, one bit per stage.
   sqrt_state_type      s_ff  [1:ROOT_W][NUM_AXES];
   sqrt_state_type      s_in  [1:ROOT_W][NUM_AXES];
   logic [NUM_AXES-1:0] sneg_ff [1:ROOT_W];
   logic                sdeg_ff [1:ROOT_W];
   logic                sv_ff   [1:ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
      for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
         if (j == 0) begin : g_first
            assign s_in[1][a] = sqrt_step('{rem: d_ff[QUO_W][a].quo, root: '0},
                                          ROOT_W - 1);
         end else begin : g_next
            assign s_in[j+1][a] = sqrt_step(s_ff[j][a], ROOT_W - 1 - j);
         end
      end
   end

   // Output: apply signs and force zero on a degenerate triangle.
   logic [RSP_DATA_W-1:0] rsp_tdata_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic                  rsp_tuser_ff;
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         if (sdeg_ff[ROOT_W]) begin
            rsp_tdata_in[a*OUT_WIDTH +: OUT_WIDTH] = '0;
         end else if (sneg_ff[ROOT_W][a]) begin
            rsp_tdata_in[a*OUT_WIDTH +: OUT_WIDTH] = -OUT_WIDTH'(s_ff[ROOT_W][a].root);
         end else begin
            rsp_tdata_in[a*OUT_WIDTH +: OUT_WIDTH] = OUT_WIDTH'(s_ff[ROOT_W][a].root);
         end
      end
   end

   // Payload registers of every stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         edge_ff <= edge_in;
         prod_ff <= prod_in;
         mag_ff  <= mag_in;
         neg3_ff <= neg3_in;
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         ll_ff   <= ll_in;
         neg4_ff <= neg3_ff;
         sq_ff   <= sq_in;
         neg5_ff <= neg4_ff;
         for (int a = 0; a < NUM_AXES; a++) begin
            d_ff[0][a].rem <= sq_ff[a];
            d_ff[0][a].quo <= '0;
         end
         dsum_ff[0] <= sum_in;
         dneg_ff[0] <= neg5_ff;
         ddeg_ff[0] <= (sum_in == '0);
         for (int k = 1; k <= QUO_W; k++) begin
            d_ff[k]    <= d_in[k];
            if (k < QUO_W) begin
               dsum_ff[k] <= dsum_ff[k-1];
            end
            dneg_ff[k] <= dneg_ff[k-1];
            ddeg_ff[k] <= ddeg_ff[k-1];
         end
         s_ff[1]    <= s_in[1];
         sneg_ff[1] <= dneg_ff[QUO_W];
         sdeg_ff[1] <= ddeg_ff[QUO_W];
         for (int j = 2; j <= ROOT_W; j++) begin
            s_ff[j]    <= s_in[j];
            sneg_ff[j] <= sneg_ff[j-1];
            sdeg_ff[j] <= sdeg_ff[j-1];
         end
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= sdeg_ff[ROOT_W];
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         for (int k = 0; k <= QUO_W; k++) begin
            dv_ff[k] <= 1'b0;
         end
         for (int j = 1; j <= ROOT_W; j++) begin
            sv_ff[j] <= 1'b0;
         end
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff    <= req_tvalid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         dv_ff[0] <= v5_ff;
         for (int k = 1; k <= QUO_W; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         sv_ff[1] <= dv_ff[QUO_W];
         for (int j = 2; j <= ROOT_W; j++) begin
            sv_ff[j] <= sv_ff[j-1];
         end
         rsp_tvalid_ff <= sv_ff[ROOT_W];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // A degenerate result carries a zero normal.
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate result with nonzero normal");

   // A proper triangle always has a nonzero component.
   a_nondeg_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata != '0)
      else $error("unit normal of a proper triangle is zero");

   // Every component stays within plus or minus one in Q1.14.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(rsp_tdata[OUT_WIDTH-1:0]) <= $signed(17'sd16384)) &&
         ($signed(rsp_tdata[OUT_WIDTH-1:0]) >= -$signed(17'sd16384)) &&
         ($signed(rsp_tdata[2*OUT_WIDTH-1:OUT_WIDTH]) <= $signed(17'sd16384)) &&
         ($signed(rsp_tdata[2*OUT_WIDTH-1:OUT_WIDTH]) >= -$signed(17'sd16384)) &&
         ($signed(rsp_tdata[3*OUT_WIDTH-1:2*OUT_WIDTH]) <= $signed(17'sd16384)) &&
         ($signed(rsp_tdata[3*OUT_WIDTH-1:2*OUT_WIDTH]) >= -$signed(17'sd16384)))
      else $error("normal component out of range");

   // An empty output slot never blocks the input side.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with free output slot");

endmodule
